[rtl/tmcpg_pkg.sv]
package tmcpg_pkg;

    localparam int GLYPH_ROWS  = 16;
    localparam int GLYPH_COUNT = 512;
    localparam int FONT_DEPTH  = GLYPH_ROWS * GLYPH_COUNT;
    localparam int ROW_AW      = $clog2(GLYPH_ROWS);
    localparam int GLYPH_AW    = $clog2(GLYPH_COUNT);
    localparam int FONT_AW     = GLYPH_AW + ROW_AW;

    localparam int FONT_ADDR_W = 13;
    localparam int GLYPH_BITS  = 8;
    localparam int COL_W       = 4;
    localparam int ROW_W       = 5;
    localparam int COLOR_W     = 4;

    localparam int CFG_COUNT   = 8;
    localparam int CFG_AW      = $clog2(CFG_COUNT) + 2;
    localparam int DATA_W      = 32;

    typedef enum logic
    {
        OP_FONT_WRITE = 1'b0,
        OP_RENDER     = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        CUR_SOLID = 2'd0,
        CUR_OFF   = 2'd1,
        CUR_FAST  = 2'd2,
        CUR_SLOW  = 2'd3
    } cursor_mode_t;

    typedef enum logic [2:0]
    {
        REG_CELL_TOTAL_HEIGHT = 3'd0,
        REG_CURSOR_CONTROL    = 3'd1,
        REG_CURSOR_END_ROW    = 3'd2,
        REG_CELL_WIDTHS       = 3'd3,
        REG_SHOWN_ROWS        = 3'd4,
        REG_MODE_FLAGS        = 3'd5,
        REG_COLORS            = 3'd6,
        REG_UNDERLINE_SCAN    = 3'd7
    } cfg_index_t;

    typedef struct packed
    {
        logic [4:0] cell_total_height;
        logic [6:0] cursor_control;
        logic [4:0] cursor_end_row;
        logic [7:0] cell_widths;
        logic [4:0] shown_rows;
        logic [2:0] mode_flags;
        logic [7:0] colors;
        logic [4:0] underline_scan;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        cell_total_height: 5'd7,
        cursor_control:    7'd0,
        cursor_end_row:    5'd7,
        cell_widths:       8'd120,
        shown_rows:        5'd8,
        mode_flags:        3'd4,
        colors:            8'd240,
        underline_scan:    5'd7
    };

    localparam logic [23:0] PALETTE [16] = '{
        24'h000000, 24'h555555, 24'h0000AA, 24'h5555FF,
        24'h00AA00, 24'h55FF55, 24'h00AAAA, 24'h55FFFF,
        24'hAA0000, 24'hFF5555, 24'hAA00AA, 24'hFF55FF,
        24'hAA5500, 24'hFFFF55, 24'hAAAAAA, 24'hFFFFFF
    };

endpackage

[rtl/tmcpg_if.sv]
interface tmcpg_in_if;
    import tmcpg_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   opcode;
    logic [FONT_ADDR_W-1:0] font_address;
    logic [7:0]             font_byte;
    logic [7:0]             char_code;
    logic [7:0]             attribute_byte;
    logic [ROW_W-1:0]       scan_row;
    logic                   cursor_here;
    logic [5:0]             frame_count;

    modport source
    (
        output valid, opcode, font_address, font_byte, char_code, attribute_byte,
               scan_row, cursor_here, frame_count,
        input  ready
    );

    modport sink
    (
        input  valid, opcode, font_address, font_byte, char_code, attribute_byte,
               scan_row, cursor_here, frame_count,
        output ready
    );
endinterface

interface tmcpg_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_pixel;

    modport source
    (
        output valid, red, green, blue, last_pixel,
        input  ready
    );

    modport sink
    (
        input  valid, red, green, blue, last_pixel,
        output ready
    );
endinterface

[rtl/tmcpg_ram.sv]
module tmcpg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

[rtl/tmcpg_regs.sv]
module tmcpg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tmcpg_pkg::CFG_AW-1:0]      paddr,
    input  logic [tmcpg_pkg::DATA_W-1:0]      pwdata,
    output logic [tmcpg_pkg::DATA_W-1:0]      prdata,
    output logic                              pready,
    output tmcpg_pkg::cfg_t                   cfg
);
    import tmcpg_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    cfg_index_t idx;

    assign idx    = cfg_index_t'(paddr[CFG_AW-1:2]);
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite)
        begin
            case (idx)
                REG_CELL_TOTAL_HEIGHT: cfg_next.cell_total_height = pwdata[4:0];
                REG_CURSOR_CONTROL:    cfg_next.cursor_control    = pwdata[6:0];
                REG_CURSOR_END_ROW:    cfg_next.cursor_end_row    = pwdata[4:0];
                REG_CELL_WIDTHS:       cfg_next.cell_widths       = pwdata[7:0];
                REG_SHOWN_ROWS:        cfg_next.shown_rows        = pwdata[4:0];
                REG_MODE_FLAGS:        cfg_next.mode_flags        = pwdata[2:0];
                REG_COLORS:            cfg_next.colors            = pwdata[7:0];
                REG_UNDERLINE_SCAN:    cfg_next.underline_scan    = pwdata[4:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (idx)
            REG_CELL_TOTAL_HEIGHT: prdata = DATA_W'(cfg_reg.cell_total_height);
            REG_CURSOR_CONTROL:    prdata = DATA_W'(cfg_reg.cursor_control);
            REG_CURSOR_END_ROW:    prdata = DATA_W'(cfg_reg.cursor_end_row);
            REG_CELL_WIDTHS:       prdata = DATA_W'(cfg_reg.cell_widths);
            REG_SHOWN_ROWS:        prdata = DATA_W'(cfg_reg.shown_rows);
            REG_MODE_FLAGS:        prdata = DATA_W'(cfg_reg.mode_flags);
            REG_COLORS:            prdata = DATA_W'(cfg_reg.colors);
            REG_UNDERLINE_SCAN:    prdata = DATA_W'(cfg_reg.underline_scan);
            default:               prdata = '0;
        endcase
    end
endmodule

[rtl/text_mode_cell_pixel_generator.sv]
// Channel  Role  Item
// req      sink  font write (opcode 0) or render one cell scan row (opcode 1)
// pix      src   one RGB pixel, last_pixel set on the final column of the cell
// apb      cfg   eight setup registers at byte address 4*i
//
// A render item emits one pixel per clock at the pixel serializer while the pixel output is not
// stalled, one for each column of the total width (1 to 16); a font write emits nothing.
// The font memory is read at acceptance; its data is ready in the next cycle and held
// until the serializer takes the item.
// Reset clears the pipeline valids and sets the setup registers to their defaults; the font memory is not cleared.
// A stalled pixel output holds the serializer, which in turn holds the accept side.
module text_mode_cell_pixel_generator (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tmcpg_pkg::CFG_AW-1:0] paddr,
    input  logic [tmcpg_pkg::DATA_W-1:0] pwdata,
    output logic [tmcpg_pkg::DATA_W-1:0] prdata,
    output logic                         pready,
    tmcpg_in_if.sink                     req,
    tmcpg_out_if.source                  pix
);
    import tmcpg_pkg::*;

    cfg_t cfg;

    tmcpg_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    logic in_fire;
    logic is_render;
    logic font_we;
    logic font_re;
    logic [FONT_AW-1:0] font_raddr;
    logic [GLYPH_BITS-1:0] font_rdata;

    logic [4:0]         cell_w;
    logic [4:0]         disp_w_raw;
    logic [4:0]         disp_w_cut;
    logic [COL_W-1:0]   disp_w;
    logic [5:0]         cell_h;
    logic [5:0]         disp_h;
    logic [4:0]         ul_row;
    logic               attrs_on;
    logic [COLOR_W-1:0] fg_pre;
    logic [COLOR_W-1:0] fg;
    logic [COLOR_W-1:0] bg;
    logic               reverse;
    logic               visible;
    logic               cur_vis;
    logic               in_range;
    logic               glyph_en;
    logic               flag;
    logic [GLYPH_AW-1:0] glyph;
    logic [4:0]         cs;
    logic [4:0]         ce;
    logic [ROW_W-1:0]   y;

    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic               s1_glyph_en_reg;
    logic               s1_flag_reg;
    logic [COL_W-1:0]   s1_disp_w_reg;
    logic [COL_W-1:0]   s1_last_reg;
    logic [COLOR_W-1:0] s1_fg_reg;
    logic [COLOR_W-1:0] s1_bg_reg;

    logic                  ser_valid_reg;
    logic                  ser_valid_next;
    logic [COL_W-1:0]      ser_col_reg;
    logic [COL_W-1:0]      ser_col_next;
    logic [COL_W-1:0]      ser_last_reg;
    logic [GLYPH_BITS-1:0] ser_on_reg;
    logic [COLOR_W-1:0]    ser_fg_reg;
    logic [COLOR_W-1:0]    ser_bg_reg;
    logic [GLYPH_BITS-1:0] on_mask;
    logic [GLYPH_BITS-1:0] glyph_bits;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [23:0] out_rgb_reg;
    logic        out_last_reg;
    logic        pix_on;
    logic [COLOR_W-1:0] pix_color;

    logic out_free;
    logic ser_fire;
    logic ser_done;
    logic ser_free;
    logic s1_move;

    assign out_free = !out_valid_reg || pix.ready;
    assign ser_fire = ser_valid_reg && out_free;
    assign ser_done = ser_fire && (ser_col_reg == ser_last_reg);
    assign ser_free = !ser_valid_reg || ser_done;
    assign s1_move  = s1_valid_reg && ser_free;

    assign req.ready = !s1_valid_reg || s1_move;
    assign in_fire   = req.valid && req.ready;
    assign is_render = (req.opcode == OP_RENDER);

    assign font_we = in_fire && !is_render
                     && ({1'b0, req.font_address} < (FONT_ADDR_W + 1)'(FONT_DEPTH));
    assign font_re = in_fire && is_render;

    tmcpg_ram #(
        .WIDTH (GLYPH_BITS),
        .DEPTH (FONT_DEPTH)
    ) u_font (
        .clk   (clk),
        .we    (font_we),
        .waddr (req.font_address[FONT_AW-1:0]),
        .wdata (req.font_byte),
        .re    (font_re),
        .raddr (font_raddr),
        .rdata (font_rdata)
    );

    always_comb
    begin
        y          = req.scan_row;
        cell_w     = {1'b0, cfg.cell_widths[7:4]} + 5'd1;
        disp_w_raw = {1'b0, cfg.cell_widths[3:0]};
        disp_w_cut = (disp_w_raw > cell_w) ? cell_w : disp_w_raw;
        disp_w     = (disp_w_cut > 5'd8) ? COL_W'(8) : disp_w_cut[COL_W-1:0];
        cell_h     = {1'b0, cfg.cell_total_height} + 6'd1;
        disp_h     = ({1'b0, cfg.shown_rows} > cell_h) ? cell_h
                                                       : {1'b0, cfg.shown_rows};

        attrs_on = cfg.mode_flags[2];
        fg_pre   = attrs_on ? req.attribute_byte[3:0] : cfg.colors[7:4];
        reverse  = cfg.mode_flags[0] ^ (attrs_on && req.attribute_byte[6]);
        fg       = reverse ? cfg.colors[3:0] : fg_pre;
        bg       = reverse ? fg_pre : cfg.colors[3:0];

        visible = !(attrs_on && req.attribute_byte[4])
                  || !(cfg.mode_flags[1] ? req.frame_count[5] : req.frame_count[4]);

        if (cfg.cell_total_height == 5'd0)
        begin
            ul_row = 5'd0;
        end
        else
        begin
            ul_row = (cfg.underline_scan > cfg.cell_total_height) ? cfg.cell_total_height
                                                                  : cfg.underline_scan;
        end

        case (cursor_mode_t'(cfg.cursor_control[6:5]))
            CUR_SOLID: cur_vis = 1'b1;
            CUR_OFF:   cur_vis = 1'b0;
            CUR_FAST:  cur_vis = !req.frame_count[4];
            CUR_SLOW:  cur_vis = !req.frame_count[5];
            default:   cur_vis = 1'b0;
        endcase

        cs = cfg.cursor_control[4:0];
        ce = cfg.cursor_end_row;
        if (cs <= ce)
        begin
            in_range = (y >= cs) && (y <= ce);
        end
        else
        begin
            in_range = (y >= cs) || (y <= ce);
        end

        glyph_en = visible && ({1'b0, y} < disp_h) && ({1'b0, y} < 6'(GLYPH_ROWS));
        flag     = (visible && attrs_on && req.attribute_byte[5] && (y == ul_row))
                   || (req.cursor_here && cur_vis && in_range);

        glyph      = GLYPH_AW'({attrs_on && req.attribute_byte[7], req.char_code});
        font_raddr = {glyph, y[ROW_AW-1:0]};
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
        if (in_fire && is_render)
        begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && is_render)
        begin
            s1_glyph_en_reg <= glyph_en;
            s1_flag_reg     <= flag;
            s1_disp_w_reg   <= disp_w;
            s1_last_reg     <= cfg.cell_widths[7:4];
            s1_fg_reg       <= fg;
            s1_bg_reg       <= bg;
        end
    end

    always_comb
    begin
        glyph_bits = s1_glyph_en_reg ? font_rdata : '0;
        for (int x = 0; x < GLYPH_BITS; x++)
        begin
            on_mask[x] = (COL_W'(x) < s1_disp_w_reg)
                         && (glyph_bits[GLYPH_BITS-1-x] || s1_flag_reg);
        end
    end

    always_comb
    begin
        ser_valid_next = ser_valid_reg;
        ser_col_next   = ser_col_reg;
        if (ser_fire)
        begin
            ser_col_next = ser_col_reg + COL_W'(1);
        end
        if (ser_done)
        begin
            ser_valid_next = 1'b0;
        end
        if (s1_move)
        begin
            ser_valid_next = 1'b1;
            ser_col_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ser_valid_reg <= 1'b0;
            ser_col_reg   <= '0;
        end
        else
        begin
            ser_valid_reg <= ser_valid_next;
            ser_col_reg   <= ser_col_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            ser_on_reg   <= on_mask;
            ser_last_reg <= s1_last_reg;
            ser_fg_reg   <= s1_fg_reg;
            ser_bg_reg   <= s1_bg_reg;
        end
    end

    assign pix_on    = (ser_col_reg < COL_W'(GLYPH_BITS))
                       && ser_on_reg[ser_col_reg[$clog2(GLYPH_BITS)-1:0]];
    assign pix_color = pix_on ? ser_fg_reg : ser_bg_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pix.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (ser_fire)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ser_fire)
        begin
            out_rgb_reg  <= PALETTE[pix_color];
            out_last_reg <= (ser_col_reg == ser_last_reg);
        end
    end

    assign pix.valid      = out_valid_reg;
    assign pix.red        = out_rgb_reg[23:16];
    assign pix.green      = out_rgb_reg[15:8];
    assign pix.blue       = out_rgb_reg[7:0];
    assign pix.last_pixel = out_last_reg;
endmodule

[sim/tb_text_mode_cell_pixel_generator.sv]
module tb_text_mode_cell_pixel_generator;
    import tmcpg_pkg::*;

    localparam int FONT_ROWS     = 16;
    localparam int FONT_SIZE     = 8192;
    localparam int SETTLE_CYCLES = 24;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 600000;

    localparam logic [23:0] RGBI_COLORS [16] = '{
        24'h000000, 24'h555555, 24'h0000AA, 24'h5555FF,
        24'h00AA00, 24'h55FF55, 24'h00AAAA, 24'h55FFFF,
        24'hAA0000, 24'hFF5555, 24'hAA00AA, 24'hFF55FF,
        24'hAA5500, 24'hFFFF55, 24'hAAAAAA, 24'hFFFFFF
    };

    localparam cfg_t POWER_ON_CFG = '{
        cell_total_height: 5'd7,
        cursor_control:    7'd0,
        cursor_end_row:    5'd7,
        cell_widths:       8'd120,
        shown_rows:        5'd8,
        mode_flags:        3'd4,
        colors:            8'd240,
        underline_scan:    5'd7
    };

    typedef struct
    {
        op_t         opcode;
        logic [12:0] font_address;
        logic [7:0]  font_byte;
        logic [7:0]  char_code;
        logic [7:0]  attribute_byte;
        logic [4:0]  scan_row;
        logic        cursor_here;
        logic [5:0]  frame_count;
    } cell_req_t;

    typedef struct packed
    {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last_pixel;
    } pixel_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    tmcpg_in_if  req_if ();
    tmcpg_out_if pix_if ();

    text_mode_cell_pixel_generator dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req_if),
        .pix     (pix_if)
    );

    cfg_t       cfg_now;
    logic [7:0] font_image [FONT_SIZE];
    bit         font_loaded [FONT_SIZE];
    pixel_t     expected_pixels [$];
    pixel_t     next_pixel;
    int         error_count = 0;
    int         cycle_count = 0;
    bit         gaps_on = 1'b1;
    bit         stalls_on = 1'b1;
    bit         hold_request = 1'b0;
    bit         hold_active = 1'b0;

    always #5 clk = ~clk;

    function automatic void mismatch(string what, logic [31:0] want, logic [31:0] got);
        error_count++;
        if (error_count <= 10)
            $display("ERROR at %0t: %s expected %0h got %0h", $time, what, want, got);
    endfunction

    function automatic logic blink_phase_on(logic [5:0] frame, logic slow);
        return slow ? !frame[5] : !frame[4];
    endfunction

    // The alternate bank adds 256 to the code, which stays within the 512 glyphs.
    function automatic logic [12:0] font_index(logic [7:0] code, logic [7:0] attr,
                                               logic [4:0] row);
        logic alt_bank;
        alt_bank = cfg_now.mode_flags[2] && attr[7];
        return {alt_bank, code, row[3:0]};
    endfunction

    function automatic void predict_cell_row(cell_req_t it);
        int unsigned  cell_w;
        int unsigned  disp_w;
        int unsigned  cell_h;
        int unsigned  disp_h;
        int unsigned  ul_row;
        int unsigned  cs;
        int unsigned  ce;
        logic [3:0]   fg;
        logic [3:0]   bg;
        logic [3:0]   swap;
        logic [3:0]   color;
        logic         underline;
        logic         blink;
        logic         cell_rev;
        logic         visible;
        logic         cur_vis;
        logic         in_range;
        logic         cursor_lit;
        logic         ul;
        logic         lit;
        logic [7:0]   bits;
        cursor_mode_t cmode;
        pixel_t       px;
        cell_w = 32'(cfg_now.cell_widths[7:4]) + 1;
        disp_w = 32'(cfg_now.cell_widths[3:0]);
        if (disp_w > cell_w)
            disp_w = cell_w;
        if (disp_w > 8)
            disp_w = 8;
        cell_h = 32'(cfg_now.cell_total_height) + 1;
        disp_h = 32'(cfg_now.shown_rows);
        if (disp_h > cell_h)
            disp_h = cell_h;
        fg = cfg_now.colors[7:4];
        bg = cfg_now.colors[3:0];
        underline = 1'b0;
        blink = 1'b0;
        cell_rev = 1'b0;
        if (cfg_now.mode_flags[2])
        begin
            fg = it.attribute_byte[3:0];
            underline = it.attribute_byte[5];
            blink = it.attribute_byte[4];
            cell_rev = it.attribute_byte[6];
        end
        if (cfg_now.mode_flags[0] != cell_rev)
        begin
            swap = fg;
            fg = bg;
            bg = swap;
        end
        visible = !blink || blink_phase_on(it.frame_count, cfg_now.mode_flags[1]);
        ul_row = 0;
        if (cell_h > 1)
        begin
            ul_row = 32'(cfg_now.underline_scan);
            if (ul_row > cell_h - 1)
                ul_row = cell_h - 1;
        end
        cmode = cursor_mode_t'(cfg_now.cursor_control[6:5]);
        case (cmode)
            CUR_SOLID: cur_vis = 1'b1;
            CUR_OFF:   cur_vis = 1'b0;
            CUR_FAST:  cur_vis = blink_phase_on(it.frame_count, 1'b0);
            default:   cur_vis = blink_phase_on(it.frame_count, 1'b1);
        endcase
        cs = 32'(cfg_now.cursor_control[4:0]);
        ce = 32'(cfg_now.cursor_end_row);
        if (cs <= ce)
            in_range = it.scan_row >= cs && it.scan_row <= ce;
        else
            in_range = it.scan_row >= cs || it.scan_row <= ce;
        cursor_lit = it.cursor_here && cur_vis && in_range;
        bits = 8'h00;
        if (visible && it.scan_row < disp_h && it.scan_row < FONT_ROWS)
            bits = font_image[font_index(it.char_code, it.attribute_byte, it.scan_row)];
        ul = visible && underline && it.scan_row == ul_row;
        for (int x = 0; x < cell_w; x++)
        begin
            lit = 1'b0;
            if (x < disp_w)
                lit = bits[7 - x] || ul || cursor_lit;
            color = lit ? fg : bg;
            px.red = RGBI_COLORS[color][23:16];
            px.green = RGBI_COLORS[color][15:8];
            px.blue = RGBI_COLORS[color][7:0];
            px.last_pixel = (x + 1 == cell_w);
            expected_pixels.push_back(px);
        end
    endfunction

    function automatic cell_req_t random_fields();
        cell_req_t it;
        it.opcode = op_t'(1'($urandom_range(0, 1)));
        it.font_address = 13'($urandom_range(0, FONT_SIZE - 1));
        it.font_byte = 8'($urandom_range(0, 255));
        it.char_code = 8'($urandom_range(0, 255));
        it.attribute_byte = 8'($urandom_range(0, 255));
        it.scan_row = 5'($urandom_range(0, 31));
        it.cursor_here = 1'($urandom_range(0, 1));
        it.frame_count = 6'($urandom_range(0, 63));
        return it;
    endfunction

    function automatic cfg_t random_cfg();
        cfg_t c;
        c.cell_total_height = 5'($urandom_range(0, 31));
        c.cursor_control = 7'($urandom_range(0, 127));
        c.cursor_end_row = 5'($urandom_range(0, 31));
        c.cell_widths = 8'($urandom_range(0, 255));
        c.shown_rows = 5'($urandom_range(0, 31));
        c.mode_flags = 3'($urandom_range(0, 7));
        c.colors = 8'($urandom_range(0, 255));
        c.underline_scan = 5'($urandom_range(0, 31));
        return c;
    endfunction

    // Unused upper bits of the data bus carry noise; the block keeps only the field.
    function automatic logic [31:0] with_noise(logic [31:0] field, int w);
        return ($urandom() << w) | field;
    endfunction

    task automatic write_reg(cfg_index_t idx, logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_CELL_TOTAL_HEIGHT: cfg_now.cell_total_height = data[4:0];
            REG_CURSOR_CONTROL:    cfg_now.cursor_control = data[6:0];
            REG_CURSOR_END_ROW:    cfg_now.cursor_end_row = data[4:0];
            REG_CELL_WIDTHS:       cfg_now.cell_widths = data[7:0];
            REG_SHOWN_ROWS:        cfg_now.shown_rows = data[4:0];
            REG_MODE_FLAGS:        cfg_now.mode_flags = data[2:0];
            REG_COLORS:            cfg_now.colors = data[7:0];
            default:               cfg_now.underline_scan = data[4:0];
        endcase
        @(posedge clk);
    endtask

    task automatic apply_config(cfg_t c);
        write_reg(REG_CELL_TOTAL_HEIGHT, with_noise(32'(c.cell_total_height), 5));
        write_reg(REG_CURSOR_CONTROL, with_noise(32'(c.cursor_control), 7));
        write_reg(REG_CURSOR_END_ROW, with_noise(32'(c.cursor_end_row), 5));
        write_reg(REG_CELL_WIDTHS, with_noise(32'(c.cell_widths), 8));
        write_reg(REG_SHOWN_ROWS, with_noise(32'(c.shown_rows), 5));
        write_reg(REG_MODE_FLAGS, with_noise(32'(c.mode_flags), 3));
        write_reg(REG_COLORS, with_noise(32'(c.colors), 8));
        write_reg(REG_UNDERLINE_SCAN, with_noise(32'(c.underline_scan), 5));
    endtask

    task automatic send_item(cell_req_t it);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.opcode <= it.opcode;
        req_if.font_address <= it.font_address;
        req_if.font_byte <= it.font_byte;
        req_if.char_code <= it.char_code;
        req_if.attribute_byte <= it.attribute_byte;
        req_if.scan_row <= it.scan_row;
        req_if.cursor_here <= it.cursor_here;
        req_if.frame_count <= it.frame_count;
        do
            @(posedge clk);
        while (req_if.ready !== 1'b1);
        if (it.opcode == OP_FONT_WRITE)
        begin
            font_image[it.font_address] = it.font_byte;
            font_loaded[it.font_address] = 1'b1;
        end
        else
            predict_cell_row(it);
    endtask

    task automatic load_font_byte(logic [12:0] addr, logic [7:0] value);
        cell_req_t it;
        it = random_fields();
        it.opcode = OP_FONT_WRITE;
        it.font_address = addr;
        it.font_byte = value;
        send_item(it);
    endtask

    // A glyph row that has never been loaded gets a random byte first.
    task automatic render(logic [7:0] code, logic [7:0] attr, logic [4:0] row,
                          logic here, logic [5:0] frame);
        cell_req_t   it;
        logic [12:0] addr;
        addr = font_index(code, attr, row);
        if (!font_loaded[addr])
            load_font_byte(addr, 8'($urandom_range(0, 255)));
        it = random_fields();
        it.opcode = OP_RENDER;
        it.char_code = code;
        it.attribute_byte = attr;
        it.scan_row = row;
        it.cursor_here = here;
        it.frame_count = frame;
        send_item(it);
    endtask

    task automatic random_item();
        int top_row;
        top_row = cfg_now.cell_total_height + 1;
        if (top_row > 31)
            top_row = 31;
        if ($urandom_range(0, 4) == 0)
            load_font_byte(13'($urandom_range(0, FONT_SIZE - 1)),
                           8'($urandom_range(0, 255)));
        else
            render(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   5'(($urandom_range(0, 3) != 0) ? $urandom_range(0, top_row)
                                                  : $urandom_range(0, 31)),
                   1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)));
    endtask

    task automatic settle();
        req_if.valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic test_reset_defaults();
        load_font_byte(13'h0000, 8'hA5);
        load_font_byte(13'h1FFF, 8'hFF);
        render(8'h41, 8'h0F, 5'd3, 1'b0, 6'd0);
        render(8'h41, 8'h8F, 5'd3, 1'b1, 6'd0);
        render(8'h00, 8'h2A, 5'd7, 1'b0, 6'd0);
        settle();
    endtask

    task automatic test_geometry();
        cfg_t c;
        c = cfg_now;
        c.cell_total_height = 5'd31;
        c.cursor_control = {CUR_OFF, 5'd0};
        c.cursor_end_row = 5'd0;
        c.cell_widths = 8'hFF;
        c.shown_rows = 5'd31;
        c.colors = 8'h1E;
        c.underline_scan = 5'd31;
        apply_config(c);
        render(8'hFF, 8'h8F, 5'd15, 1'b0, 6'd0);
        render(8'hFF, 8'h0F, 5'd16, 1'b0, 6'd0);
        render(8'h00, 8'hA3, 5'd31, 1'b0, 6'd0);
        settle();
        c.cell_total_height = 5'd0;
        c.cell_widths = 8'h00;
        c.underline_scan = 5'd9;
        apply_config(c);
        render(8'h10, 8'h25, 5'd0, 1'b0, 6'd0);
        render(8'h10, 8'h25, 5'd5, 1'b0, 6'd0);
        settle();
        c.cell_total_height = 5'd3;
        c.cell_widths = 8'h3F;
        apply_config(c);
        render(8'h20, 8'h2C, 5'd3, 1'b0, 6'd0);
        settle();
    endtask

    task automatic test_attributes();
        cfg_t c;
        c = POWER_ON_CFG;
        c.colors = 8'h9C;
        c.underline_scan = 5'd6;
        c.mode_flags = 3'd0;
        apply_config(c);
        render(8'h41, 8'hFF, 5'd2, 1'b0, 6'd0);
        settle();
        write_reg(REG_MODE_FLAGS, 32'd1);
        render(8'h41, 8'hFF, 5'd2, 1'b0, 6'd0);
        settle();
        write_reg(REG_MODE_FLAGS, 32'd5);
        render(8'h41, 8'h4A, 5'd2, 1'b0, 6'd0);
        settle();
        write_reg(REG_MODE_FLAGS, 32'd4);
        render(8'h41, 8'h3C, 5'd6, 1'b0, 6'h00);
        render(8'h41, 8'h3C, 5'd6, 1'b0, 6'h10);
        settle();
        write_reg(REG_MODE_FLAGS, 32'd6);
        render(8'h41, 8'h3C, 5'd6, 1'b0, 6'h10);
        render(8'h41, 8'h3C, 5'd6, 1'b0, 6'h20);
        settle();
    endtask

    task automatic test_cursor();
        cfg_t c;
        c = POWER_ON_CFG;
        c.cursor_control = {CUR_SOLID, 5'd2};
        c.cursor_end_row = 5'd5;
        apply_config(c);
        render(8'h41, 8'h07, 5'd3, 1'b1, 6'd0);
        render(8'h41, 8'h07, 5'd3, 1'b0, 6'd0);
        settle();
        write_reg(REG_CURSOR_CONTROL, {25'd0, CUR_OFF, 5'd2});
        render(8'h41, 8'h07, 5'd3, 1'b1, 6'd0);
        settle();
        write_reg(REG_CURSOR_CONTROL, {25'd0, CUR_FAST, 5'd2});
        render(8'h41, 8'h07, 5'd3, 1'b1, 6'h10);
        render(8'h41, 8'h07, 5'd3, 1'b1, 6'h00);
        settle();
        write_reg(REG_CURSOR_CONTROL, {25'd0, CUR_SLOW, 5'd2});
        render(8'h41, 8'h07, 5'd3, 1'b1, 6'h20);
        render(8'h41, 8'h07, 5'd3, 1'b1, 6'h1F);
        settle();
        write_reg(REG_CURSOR_CONTROL, {25'd0, CUR_SOLID, 5'd6});
        write_reg(REG_CURSOR_END_ROW, 32'd1);
        render(8'h41, 8'h07, 5'd7, 1'b1, 6'd0);
        render(8'h41, 8'h07, 5'd0, 1'b1, 6'd0);
        render(8'h41, 8'h07, 5'd3, 1'b1, 6'd0);
        settle();
    endtask

    task automatic test_random_settings();
        cfg_t c;
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:       c = '0;
                1:       c = '1;
                default: c = random_cfg();
            endcase
            apply_config(c);
            for (int n = 0; n < 18; n++)
                random_item();
            settle();
        end
    endtask

    task automatic test_output_backpressure();
        cfg_t c;
        c = random_cfg();
        c.cell_widths = 8'h77;
        apply_config(c);
        gaps_on = 1'b0;
        hold_request = 1'b1;
        while (!hold_active)
            @(posedge clk);
        for (int n = 0; n < 30; n++)
            random_item();
        settle();
        gaps_on = 1'b1;
    endtask

    task automatic test_full_rate();
        gaps_on = 1'b0;
        stalls_on = 1'b0;
        apply_config(random_cfg());
        for (int n = 0; n < 30; n++)
            random_item();
        settle();
    endtask

    initial
    begin
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        req_if.valid <= 1'b0;
        req_if.opcode <= OP_FONT_WRITE;
        req_if.font_address <= '0;
        req_if.font_byte <= '0;
        req_if.char_code <= '0;
        req_if.attribute_byte <= '0;
        req_if.scan_row <= '0;
        req_if.cursor_here <= 1'b0;
        req_if.frame_count <= '0;
        cfg_now = POWER_ON_CFG;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_geometry();
        test_attributes();
        test_cursor();
        test_random_settings();
        test_output_backpressure();
        test_full_rate();
        if (expected_pixels.size() != 0)
            mismatch("pixels never delivered", 0, expected_pixels.size());
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        pix_if.ready <= 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                pix_if.ready <= 1'b0;
                hold_active = 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
                hold_active = 1'b0;
            end
            else if (stalls_on && $urandom_range(0, 2) == 0)
            begin
                pix_if.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            else
            begin
                pix_if.ready <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && pix_if.valid === 1'b1 && pix_if.ready === 1'b1)
        begin
            if (expected_pixels.size() == 0)
                mismatch("pixel with none pending", 0,
                         32'({pix_if.red, pix_if.green, pix_if.blue, pix_if.last_pixel}));
            else
            begin
                next_pixel = expected_pixels.pop_front();
                if (pix_if.red !== next_pixel.red)
                    mismatch("red", 32'(next_pixel.red), 32'(pix_if.red));
                if (pix_if.green !== next_pixel.green)
                    mismatch("green", 32'(next_pixel.green), 32'(pix_if.green));
                if (pix_if.blue !== next_pixel.blue)
                    mismatch("blue", 32'(next_pixel.blue), 32'(pix_if.blue));
                if (pix_if.last_pixel !== next_pixel.last_pixel)
                    mismatch("last_pixel", 32'(next_pixel.last_pixel),
                             32'(pix_if.last_pixel));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

endmodule
